/* hw/rtl/swhs_pkg.sv */
// Shared types and constants for the single-wire humidity sensor reader.
package swhs_pkg;

   // Frame layout: two data words and a checksum byte, sent MSB first
   localparam int unsigned DATA_WORDS  = 2;
   localparam int unsigned WORD_BITS   = 16;
   localparam int unsigned CHECK_BITS  = 8;
   localparam int unsigned TOTAL_BITS  = DATA_WORDS * WORD_BITS + CHECK_BITS;
   localparam int unsigned BIT_INDEX_W = 6;
   localparam int unsigned TICK_W      = 16;
   localparam int unsigned CSR_INDEX_W = 3;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_START_LOW     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_HIGH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESPONSE_WAIT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESPONSE_CHK  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_SAMPLE    = 3'd4;

   // Register reset values, in ticks
   localparam logic [TICK_W-1:0] START_LOW_RESET     = 16'd1200;
   localparam logic [TICK_W-1:0] RELEASE_HIGH_RESET  = 16'd30;
   localparam logic [TICK_W-1:0] RESPONSE_WAIT_RESET = 16'd40;
   localparam logic [TICK_W-1:0] RESPONSE_CHK_RESET  = 16'd80;
   localparam logic [TICK_W-1:0] BIT_SAMPLE_RESET    = 16'd40;

   // Timing configuration seen by the sequencer
   typedef struct packed {
      logic [TICK_W-1:0] start_low_ticks;
      logic [TICK_W-1:0] release_high_ticks;
      logic [TICK_W-1:0] response_wait_ticks;
      logic [TICK_W-1:0] response_check_ticks;
      logic [TICK_W-1:0] bit_sample_ticks;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic                  drive_enable;
      logic                  drive_level;
      logic                  busy_res;
      logic                  done_res;
      logic [WORD_BITS-1:0]  first_word;
      logic [WORD_BITS-1:0]  second_word;
      logic [CHECK_BITS-1:0] received_checksum;
      logic                  checksum_ok;
      logic                  response_failed;
   } result_type;

endpackage

/* hw/rtl/swhs_csr.sv */
// Timing configuration registers of the single-wire humidity sensor reader.
module swhs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [swhs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [swhs_pkg::TICK_W-1:0]        csr_write_data,
   output swhs_pkg::cfg_type                  cfg
);

   swhs_pkg::cfg_type cfg_ff;
   swhs_pkg::cfg_type cfg_in;

   // Pick the addressed register; drop writes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            swhs_pkg::CSR_START_LOW:     cfg_in.start_low_ticks      = csr_write_data;
            swhs_pkg::CSR_RELEASE_HIGH:  cfg_in.release_high_ticks   = csr_write_data;
            swhs_pkg::CSR_RESPONSE_WAIT: cfg_in.response_wait_ticks  = csr_write_data;
            swhs_pkg::CSR_RESPONSE_CHK:  cfg_in.response_check_ticks = csr_write_data;
            swhs_pkg::CSR_BIT_SAMPLE:    cfg_in.bit_sample_ticks     = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low_ticks      <= swhs_pkg::START_LOW_RESET;
         cfg_ff.release_high_ticks   <= swhs_pkg::RELEASE_HIGH_RESET;
         cfg_ff.response_wait_ticks  <= swhs_pkg::RESPONSE_WAIT_RESET;
         cfg_ff.response_check_ticks <= swhs_pkg::RESPONSE_CHK_RESET;
         cfg_ff.bit_sample_ticks     <= swhs_pkg::BIT_SAMPLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/swhs_ctrl.sv */
// Bus sequencer: start pulse, response check, bit reception and checksum.
module swhs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   start_request,
   input  logic                   line_level,
   input  swhs_pkg::cfg_type      cfg,
   output swhs_pkg::result_type   result
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START_LOW,
      PH_DRIVE_HIGH,
      PH_RESP_WAIT,
      PH_RESP_CHECK,
      PH_RESP_END,
      PH_BIT_HIGH,
      PH_BIT_DELAY,
      PH_BIT_LOW
   } phase_type;

   localparam int unsigned FRAME_W = swhs_pkg::TOTAL_BITS;
   localparam int unsigned WB      = swhs_pkg::WORD_BITS;
   localparam int unsigned CB      = swhs_pkg::CHECK_BITS;

   phase_type                           phase_ff, phase_in;
   logic [swhs_pkg::TICK_W-1:0]         tick_ff, tick_in;
   logic [swhs_pkg::BIT_INDEX_W-1:0]    bit_idx_ff, bit_idx_in;
   logic [FRAME_W-1:0]                  shift_ff, shift_in;
   logic                                fail_ff, fail_in;
   logic [FRAME_W-1:0]                  last_ff, last_in;
   logic                                last_ok_ff, last_ok_in;

   logic [swhs_pkg::TICK_W-1:0]         limit;
   logic                                due;
   logic [swhs_pkg::TICK_W-1:0]         tick_inc;
   logic [7:0]                          byte_sum;
   logic                                done;

   // Select the limit of the timed phase in progress
   always_comb begin
      case (phase_ff)
         PH_START_LOW:  limit = cfg.start_low_ticks;
         PH_DRIVE_HIGH: limit = cfg.release_high_ticks;
         PH_RESP_WAIT:  limit = cfg.response_wait_ticks;
         PH_RESP_CHECK: limit = cfg.response_check_ticks;
         PH_BIT_DELAY:  limit = cfg.bit_sample_ticks;
         default:       limit = '0;
      endcase
   end

   assign due      = (tick_ff >= limit);
   assign tick_inc = tick_ff + 16'd1;

   // Byte sum of the two data words, modulo 256
   assign byte_sum = shift_ff[39:32] + shift_ff[31:24] + shift_ff[23:16] + shift_ff[15:8];

   // Advance the sequencer by one tick
   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bit_idx_in = bit_idx_ff;
      shift_in   = shift_ff;
      fail_in    = fail_ff;
      last_in    = last_ff;
      last_ok_in = last_ok_ff;
      done       = 1'b0;
      if (step) begin
         case (phase_ff)
            PH_IDLE: begin
               if (start_request) begin
                  fail_in    = 1'b0;
                  bit_idx_in = '0;
                  shift_in   = '0;
                  phase_in   = PH_START_LOW;
                  tick_in    = 16'd1;
               end
            end
            PH_START_LOW: begin
               if (due) begin
                  phase_in = PH_DRIVE_HIGH;
                  tick_in  = 16'd1;
               end else begin
                  tick_in = tick_inc;
               end
            end
            PH_DRIVE_HIGH: begin
               if (due) begin
                  phase_in = PH_RESP_WAIT;
                  tick_in  = 16'd1;
               end else begin
                  tick_in = tick_inc;
               end
            end
            PH_RESP_WAIT: begin
               if (due) begin
                  phase_in = line_level ? PH_RESP_END : PH_RESP_CHECK;
                  tick_in  = 16'd1;
               end else begin
                  tick_in = tick_inc;
               end
            end
            PH_RESP_CHECK: begin
               if (due) begin
                  fail_in  = ~line_level;
                  phase_in = PH_RESP_END;
                  tick_in  = 16'd1;
               end else begin
                  tick_in = tick_inc;
               end
            end
            PH_RESP_END: begin
               if (!line_level) begin
                  bit_idx_in = '0;
                  phase_in   = PH_BIT_HIGH;
                  tick_in    = 16'd1;
               end
            end
            PH_BIT_HIGH: begin
               if (line_level) begin
                  phase_in = PH_BIT_DELAY;
                  tick_in  = 16'd1;
               end
            end
            PH_BIT_DELAY: begin
               if (due) begin
                  shift_in   = {shift_ff[FRAME_W-2:0], line_level};
                  bit_idx_in = bit_idx_ff + 6'd1;
                  phase_in   = PH_BIT_LOW;
                  tick_in    = 16'd1;
               end else begin
                  tick_in = tick_inc;
               end
            end
            PH_BIT_LOW: begin
               if (!line_level) begin
                  if (bit_idx_ff >= swhs_pkg::BIT_INDEX_W'(FRAME_W)) begin
                     last_in    = shift_ff;
                     last_ok_in = (byte_sum == shift_ff[CB-1:0]);
                     done       = 1'b1;
                     phase_in   = PH_IDLE;
                     tick_in    = '0;
                  end else begin
                     phase_in = PH_BIT_HIGH;
                     tick_in  = 16'd1;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
               tick_in  = '0;
            end
         endcase
      end
   end

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         tick_ff    <= '0;
         bit_idx_ff <= '0;
         shift_ff   <= '0;
         fail_ff    <= 1'b0;
         last_ff    <= '0;
         last_ok_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         bit_idx_ff <= bit_idx_in;
         shift_ff   <= shift_in;
         fail_ff    <= fail_in;
         last_ff    <= last_in;
         last_ok_ff <= last_ok_in;
      end
   end

   // Form the result item from the state after this tick
   always_comb begin
      result.drive_enable      = (phase_in == PH_IDLE) || (phase_in == PH_DRIVE_HIGH)
                                 || (phase_in == PH_START_LOW);
      result.drive_level       = (phase_in == PH_IDLE) || (phase_in == PH_DRIVE_HIGH);
      result.busy_res          = (phase_in != PH_IDLE);
      result.done_res          = done;
      result.first_word        = last_in[CB+2*WB-1:CB+WB];
      result.second_word       = last_in[CB+WB-1:CB];
      result.received_checksum = last_in[CB-1:0];
      result.checksum_ok       = last_ok_in;
      result.response_failed   = fail_in;
   end

endmodule

/* hw/rtl/single_wire_humidity_sensor_reader.sv */
// Top level of the single-wire humidity sensor reader: item registers and control.
//
// Usage:
//   Send one req_ item per microsecond tick, carrying the sampled data line
//   level and a start request. Every accepted item yields exactly one rsp_
//   item showing the line drive and the reading state after that tick.
//   On a start request while idle the block pulls the line low, drives it
//   high, releases it, checks the sensor response and reads a 40-bit frame
//   (two 16-bit words and a checksum byte). rsp_done_res pulses on the item
//   that completes a reading; the words and checksum flag then hold until
//   the next reading completes.
// Timing:
//   An item passes through one input register and one result register with
//   the sequencer logic between them, so rsp_valid rises once the item has
//   been registered in both. Throughput is one item per cycle while the result
//   is not stalled; the input register takes a new item while a result is
//   still waiting, and req_stall rises only when both registers are full
//   and rsp_stall is high.
// Reset:
//   Synchronous, active high. Clears both valid flags, returns the sequencer
//   to idle with the line driven high, and loads the default timings.
module single_wire_humidity_sensor_reader (
   input  logic                                  clock,
   input  logic                                  reset,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_start_request,
   input  logic                                  req_line_level,
   // result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_drive_enable,
   output logic                                  rsp_drive_level,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic [swhs_pkg::WORD_BITS-1:0]        rsp_first_word,
   output logic [swhs_pkg::WORD_BITS-1:0]        rsp_second_word,
   output logic [swhs_pkg::CHECK_BITS-1:0]       rsp_received_checksum,
   output logic                                  rsp_checksum_ok,
   output logic                                  rsp_response_failed,
   // configuration
   input  logic                                  csr_write_enable,
   input  logic [swhs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [swhs_pkg::TICK_W-1:0]           csr_write_data
);

   swhs_pkg::cfg_type     cfg;
   swhs_pkg::result_type  result;

   logic                  in_valid_ff, in_valid_in;
   logic                  in_start_ff;
   logic                  in_line_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   swhs_pkg::result_type  rsp_data_ff;

   logic                  out_free;
   logic                  advance;
   logic                  accept;

   swhs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   swhs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .start_request (in_start_ff),
      .line_level    (in_line_ff),
      .cfg           (cfg),
      .result        (result)
   );

   // Move an item on when the result register is empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture item payloads
   always_ff @(posedge clock) begin
      if (accept) begin
         in_start_ff <= req_start_request;
         in_line_ff  <= req_line_level;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_drive_enable      = rsp_data_ff.drive_enable;
   assign rsp_drive_level       = rsp_data_ff.drive_level;
   assign rsp_busy_res          = rsp_data_ff.busy_res;
   assign rsp_done_res          = rsp_data_ff.done_res;
   assign rsp_first_word        = rsp_data_ff.first_word;
   assign rsp_second_word       = rsp_data_ff.second_word;
   assign rsp_received_checksum = rsp_data_ff.received_checksum;
   assign rsp_checksum_ok       = rsp_data_ff.checksum_ok;
   assign rsp_response_failed   = rsp_data_ff.response_failed;

`ifndef SYNTHESIS
   // A held input item always reaches the result register next cycle when it is free
   a_item_moves_on: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_free) |=> rsp_valid_ff)
      else $error("input item not moved to result register");

   // An idle result always shows the line driven high
   a_idle_drives_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_busy_res) |-> (rsp_drive_enable && rsp_drive_level))
      else $error("idle result does not drive the line high");

   // A completed reading leaves the sequencer idle
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_res) |-> !rsp_busy_res)
      else $error("done reported while still busy");

   // A full input register with a stalled result register blocks new items
   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && rsp_stall) |=> (in_valid_ff && rsp_valid_ff))
      else $error("item lost while both registers were full");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the single-wire humidity sensor reader.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LIMIT_CYCLES    = 100_000;
   localparam int unsigned HOLD_OFF_CYCLES = 60;
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned WORD_W          = swhs_pkg::WORD_BITS;
   localparam int unsigned CHECK_W         = swhs_pkg::CHECK_BITS;
   localparam int unsigned FRAME_W         = swhs_pkg::TOTAL_BITS;
   localparam int unsigned TICK_W          = swhs_pkg::TICK_W;
   localparam int unsigned INDEX_W         = swhs_pkg::CSR_INDEX_W;
   localparam int unsigned BITS_W          = swhs_pkg::BIT_INDEX_W;

   // Sequencer phases as the block walks through one reading
   typedef enum logic [3:0] {
      SQ_IDLE, SQ_START_LOW, SQ_DRIVE_HIGH, SQ_RESP_WAIT, SQ_RESP_CHECK,
      SQ_RESP_END, SQ_BIT_HIGH, SQ_BIT_DELAY, SQ_BIT_LOW
   } seq_phase_type;

   // How the emulated sensor answers the start pulse
   typedef enum logic [1:0] {RESP_NORMAL, RESP_EARLY_HIGH, RESP_NO_ACK} sensor_reply_type;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_ALTERNATE, STALL_HEAVY}
      stall_style_type;

   typedef enum logic [1:0] {EV_NONE, EV_HOLD_OFF, EV_PAUSE} phase_event_type;

   // One row of the directed table; want is used only where typed is set
   typedef struct packed {
      logic                 start;
      logic                 line;
      logic                 typed;
      swhs_pkg::result_type want;
   } stim_row_type;

   localparam swhs_pkg::result_type NO_RES     = '0;
   localparam swhs_pkg::result_type IDLE_RES   =
      '{1'b1, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0, 8'h0, 1'b0, 1'b0};
   localparam swhs_pkg::result_type PULL_RES   =
      '{1'b1, 1'b0, 1'b1, 1'b0, 16'h0, 16'h0, 8'h0, 1'b0, 1'b0};
   localparam swhs_pkg::result_type PUSH_RES   =
      '{1'b1, 1'b1, 1'b1, 1'b0, 16'h0, 16'h0, 8'h0, 1'b0, 1'b0};
   localparam swhs_pkg::result_type LISTEN_RES =
      '{1'b0, 1'b0, 1'b1, 1'b0, 16'h0, 16'h0, 8'h0, 1'b0, 1'b0};

   // Walked with every timing register at one tick
   localparam stim_row_type DIR_TAB [0:12] = '{
      '{1'b0, 1'b0, 1'b1, IDLE_RES},   // idle, line low
      '{1'b0, 1'b1, 1'b1, IDLE_RES},   // idle, line high
      '{1'b1, 1'b1, 1'b1, PULL_RES},   // start: pull the line low
      '{1'b1, 1'b0, 1'b1, PUSH_RES},   // start while busy is ignored
      '{1'b0, 1'b0, 1'b1, LISTEN_RES}, // release the line
      '{1'b1, 1'b1, 1'b1, LISTEN_RES}, // sensor already high at the first sample
      '{1'b0, 1'b1, 1'b1, LISTEN_RES}, // still waiting for low
      '{1'b0, 1'b0, 1'b0, NO_RES},
      '{1'b1, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b1, 1'b0, NO_RES},
      '{1'b0, 1'b1, 1'b0, NO_RES},
      '{1'b1, 1'b1, 1'b0, NO_RES},
      '{1'b0, 1'b0, 1'b0, NO_RES}
   };

   localparam swhs_pkg::cfg_type ONE_TIMING   = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
   localparam swhs_pkg::cfg_type RESET_TIMING = '{swhs_pkg::START_LOW_RESET,
                                                  swhs_pkg::RELEASE_HIGH_RESET,
                                                  swhs_pkg::RESPONSE_WAIT_RESET,
                                                  swhs_pkg::RESPONSE_CHK_RESET,
                                                  swhs_pkg::BIT_SAMPLE_RESET};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_start_request = 1'b0;
   logic                   req_line_level = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_drive_enable;
   logic                   rsp_drive_level;
   logic                   rsp_busy_res;
   logic                   rsp_done_res;
   logic [WORD_W-1:0]      rsp_first_word;
   logic [WORD_W-1:0]      rsp_second_word;
   logic [CHECK_W-1:0]     rsp_received_checksum;
   logic                   rsp_checksum_ok;
   logic                   rsp_response_failed;
   logic                   csr_write_enable = 1'b0;
   logic [INDEX_W-1:0]     csr_index = '0;
   logic [TICK_W-1:0]      csr_write_data = '0;

   // Mirror of the sequencer
   swhs_pkg::cfg_type      timing;
   seq_phase_type          sq_phase;
   logic [TICK_W-1:0]      sq_ticks;
   logic [BITS_W-1:0]      sq_bits;
   logic [FRAME_W-1:0]     sq_shift;
   logic [FRAME_W-1:0]     sq_last;
   logic                   sq_fail;
   logic                   sq_ok;
   int unsigned            reads_done = 0;

   // Emulated sensor for the reading in progress
   logic [FRAME_W-1:0]     sn_frame;
   sensor_reply_type       sn_resp;
   logic                   sn_noisy;

   swhs_pkg::result_type   expected_status [$];
   int unsigned            fail_count = 0;
   int unsigned            burst_left = 0;
   logic                   hold_off_req = 1'b0;
   int unsigned            hold_left = 0;
   int unsigned            style_left = 0;
   stall_style_type        style = STALL_NONE;

   single_wire_humidity_sensor_reader i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_start_request     (req_start_request),
      .req_line_level        (req_line_level),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_drive_enable      (rsp_drive_enable),
      .rsp_drive_level       (rsp_drive_level),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_first_word        (rsp_first_word),
      .rsp_second_word       (rsp_second_word),
      .rsp_received_checksum (rsp_received_checksum),
      .rsp_checksum_ok       (rsp_checksum_ok),
      .rsp_response_failed   (rsp_response_failed),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Return the mirror to its post-reset state
   function automatic void reset_reader();
      timing   = RESET_TIMING;
      sq_phase = SQ_IDLE;
      sq_ticks = '0;
      sq_bits  = '0;
      sq_shift = '0;
      sq_last  = '0;
      sq_fail  = 1'b0;
      sq_ok    = 1'b0;
   endfunction

   // True once the timed phase has run its limit; otherwise count one tick
   function automatic logic tick_due(logic [TICK_W-1:0] limit);
      if (sq_ticks >= limit) return 1'b1;
      sq_ticks++;
      return 1'b0;
   endfunction

   function automatic void enter_phase(seq_phase_type next);
      sq_phase = next;
      sq_ticks = TICK_W'(1);
   endfunction

   // Advance the mirror by one tick and give the status it should report
   function automatic swhs_pkg::result_type reader_tick(logic start, logic line);
      swhs_pkg::result_type r;
      logic                 done;
      logic [7:0]           sum;
      done = 1'b0;
      case (sq_phase)
         SQ_IDLE: if (start) begin
            sq_fail  = 1'b0;
            sq_bits  = '0;
            sq_shift = '0;
            enter_phase(SQ_START_LOW);
         end
         SQ_START_LOW: if (tick_due(timing.start_low_ticks)) enter_phase(SQ_DRIVE_HIGH);
         SQ_DRIVE_HIGH: if (tick_due(timing.release_high_ticks)) enter_phase(SQ_RESP_WAIT);
         SQ_RESP_WAIT: if (tick_due(timing.response_wait_ticks)) begin
            enter_phase(line ? SQ_RESP_END : SQ_RESP_CHECK);
         end
         SQ_RESP_CHECK: if (tick_due(timing.response_check_ticks)) begin
            sq_fail = !line;
            enter_phase(SQ_RESP_END);
         end
         SQ_RESP_END: if (!line) begin
            sq_bits = '0;
            enter_phase(SQ_BIT_HIGH);
         end
         SQ_BIT_HIGH: if (line) enter_phase(SQ_BIT_DELAY);
         SQ_BIT_DELAY: if (tick_due(timing.bit_sample_ticks)) begin
            sq_shift = {sq_shift[FRAME_W-2:0], line};
            sq_bits++;
            enter_phase(SQ_BIT_LOW);
         end
         SQ_BIT_LOW: if (!line) begin
            if (sq_bits >= FRAME_W) begin
               // frame complete: checksum is the byte sum of both words
               sum      = sq_shift[39:32] + sq_shift[31:24] + sq_shift[23:16] + sq_shift[15:8];
               sq_last  = sq_shift;
               sq_ok    = (sum == sq_shift[7:0]);
               done     = 1'b1;
               sq_phase = SQ_IDLE;
               sq_ticks = '0;
               reads_done++;
            end else begin
               enter_phase(SQ_BIT_HIGH);
            end
         end
         default: begin
            sq_phase = SQ_IDLE;
            sq_ticks = '0;
         end
      endcase
      r.drive_enable      = (sq_phase == SQ_IDLE) || (sq_phase == SQ_DRIVE_HIGH) ||
                            (sq_phase == SQ_START_LOW);
      r.drive_level       = (sq_phase == SQ_IDLE) || (sq_phase == SQ_DRIVE_HIGH);
      r.busy_res          = (sq_phase != SQ_IDLE);
      r.done_res          = done;
      r.first_word        = sq_last[39:24];
      r.second_word       = sq_last[23:8];
      r.received_checksum = sq_last[7:0];
      r.checksum_ok       = sq_ok;
      r.response_failed   = sq_fail;
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(4))
         0:       return '0;
         1:       return '1;
         default: return WORD_W'($urandom);
      endcase
   endfunction

   // Choose what the sensor sends for the next reading
   function automatic void pick_frame();
      logic [WORD_W-1:0]  hum, temp;
      logic [CHECK_W-1:0] chk;
      hum  = pick_word();
      temp = pick_word();
      chk  = hum[15:8] + hum[7:0] + temp[15:8] + temp[7:0];
      if ($urandom_range(3) == 0) chk = CHECK_W'($urandom);
      sn_frame = {hum, temp, chk};
      sn_noisy = ($urandom_range(4) == 0);
      sn_resp  = sensor_reply_type'($urandom_range(2));
   endfunction

   // Line level the sensor shows in the current phase
   function automatic logic sensor_line();
      if (sn_noisy) return 1'($urandom_range(1));
      case (sq_phase)
         SQ_RESP_WAIT:  return sn_resp == RESP_EARLY_HIGH;
         SQ_RESP_CHECK: return sn_resp != RESP_NO_ACK;
         SQ_BIT_HIGH:   return $urandom_range(3) != 0;
         SQ_BIT_DELAY:  return sn_frame[FRAME_W - 1 - sq_bits];
         SQ_BIT_LOW:    return $urandom_range(3) == 0;
         default:       return 1'($urandom_range(1));
      endcase
   endfunction

   function automatic swhs_pkg::cfg_type random_timing(int unsigned lo, int unsigned hi);
      swhs_pkg::cfg_type c;
      c.start_low_ticks      = TICK_W'($urandom_range(hi, lo));
      c.release_high_ticks   = TICK_W'($urandom_range(hi, lo));
      c.response_wait_ticks  = TICK_W'($urandom_range(hi, lo));
      c.response_check_ticks = TICK_W'($urandom_range(hi, lo));
      c.bit_sample_ticks     = TICK_W'($urandom_range(hi, lo));
      return c;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Insert a gap between bursts of items
   task automatic pace();
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         if ($urandom_range(5) == 0) burst_left = $urandom_range(150, 60);
         else burst_left = $urandom_range(24, 1);
      end
      burst_left--;
   endtask

   // Offer one item, hold it until taken, then record its expected status
   task automatic send_item(logic start, logic line, logic typed,
                            swhs_pkg::result_type want);
      swhs_pkg::result_type r;
      pace();
      req_valid         <= 1'b1;
      req_start_request <= start;
      req_line_level    <= line;
      do @(posedge clock); while (req_stall);
      r = reader_tick(start, line);
      expected_status.push_back(typed ? want : r);
   endtask

   // Stop offering and wait for every outstanding status item
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [INDEX_W-1:0] idx, logic [TICK_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         swhs_pkg::CSR_START_LOW:     timing.start_low_ticks      = data;
         swhs_pkg::CSR_RELEASE_HIGH:  timing.release_high_ticks   = data;
         swhs_pkg::CSR_RESPONSE_WAIT: timing.response_wait_ticks  = data;
         swhs_pkg::CSR_RESPONSE_CHK:  timing.response_check_ticks = data;
         swhs_pkg::CSR_BIT_SAMPLE:    timing.bit_sample_ticks     = data;
         default: ;
      endcase
   endtask

   // Load all timings; optionally hit the unused indexes, which must be ignored
   task automatic set_timing(swhs_pkg::cfg_type c, logic stray);
      write_reg(swhs_pkg::CSR_START_LOW, c.start_low_ticks);
      write_reg(swhs_pkg::CSR_RELEASE_HIGH, c.release_high_ticks);
      write_reg(swhs_pkg::CSR_RESPONSE_WAIT, c.response_wait_ticks);
      write_reg(swhs_pkg::CSR_RESPONSE_CHK, c.response_check_ticks);
      write_reg(swhs_pkg::CSR_BIT_SAMPLE, c.bit_sample_ticks);
      if (stray) begin
         for (int k = int'(swhs_pkg::CSR_BIT_SAMPLE) + 1; k < (1 << INDEX_W); k++) begin
            write_reg(k[INDEX_W-1:0], TICK_W'($urandom));
         end
      end
      csr_write_enable <= 1'b0;
   endtask

   // Run readings with random content, then finish the one in progress
   task automatic run_phase(int unsigned n_items, int unsigned want_reads,
                            phase_event_type ev);
      int unsigned sent;
      int unsigned reads_at_start;
      logic        start, line;
      sent           = 0;
      reads_at_start = reads_done;
      while (sent < n_items || reads_done - reads_at_start < want_reads ||
             sq_phase != SQ_IDLE) begin
         if (sent == n_items / 2) begin
            if (ev == EV_HOLD_OFF) hold_off_req = 1'b1;
            else if (ev == EV_PAUSE) drain();
         end
         if (sq_phase == SQ_IDLE) begin
            if (sent < n_items) start = ($urandom_range(2) == 0);
            else start = 1'b1;
            if (start) pick_frame();
            line = 1'($urandom_range(1));
         end else begin
            start = 1'($urandom_range(1));
            line  = sensor_line();
         end
         send_item(start, line, 1'b0, NO_RES);
         sent++;
      end
   endtask

   // Receiver: stall in changing styles, with an occasional long hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_off_req) begin
         hold_off_req = 1'b0;
         hold_left    = HOLD_OFF_CYCLES - 1;
         rsp_stall   <= 1'b1;
      end else begin
         if (style_left == 0) begin
            style      = stall_style_type'($urandom_range(3));
            style_left = $urandom_range(128, 16);
         end
         style_left--;
         case (style)
            STALL_NONE:      rsp_stall <= 1'b0;
            STALL_LIGHT:     rsp_stall <= ($urandom_range(7) == 0);
            STALL_ALTERNATE: rsp_stall <= ~rsp_stall;
            default:         rsp_stall <= ($urandom_range(1) == 1);
         endcase
      end
   end

   // Compare each accepted status item with the oldest expectation
   always @(posedge clock) begin : status_check
      swhs_pkg::result_type want, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_drive_enable, rsp_drive_level, rsp_busy_res, rsp_done_res,
                rsp_first_word, rsp_second_word, rsp_received_checksum,
                rsp_checksum_ok, rsp_response_failed};
         if (expected_status.size() == 0) begin
            $display("%0t: status item with nothing expected, got %0h", $time, got);
            fail_count++;
         end else begin
            want = expected_status.pop_front();
            check_field("drive_enable", want.drive_enable, got.drive_enable);
            check_field("drive_level", want.drive_level, got.drive_level);
            check_field("busy_res", want.busy_res, got.busy_res);
            check_field("done_res", want.done_res, got.done_res);
            check_field("first_word", want.first_word, got.first_word);
            check_field("second_word", want.second_word, got.second_word);
            check_field("received_checksum", want.received_checksum,
                        got.received_checksum);
            check_field("checksum_ok", want.checksum_ok, got.checksum_ok);
            check_field("response_failed", want.response_failed, got.response_failed);
         end
      end
   end

   // Give up if the run never completes
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      reset_reader();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed walk with the shortest timings
      set_timing(ONE_TIMING, 1'b0);
      pick_frame();
      for (int i = 0; i < $size(DIR_TAB); i++) begin
         send_item(DIR_TAB[i].start, DIR_TAB[i].line, DIR_TAB[i].typed, DIR_TAB[i].want);
      end
      run_phase(200, 1, EV_NONE);

      // Zero timings behave as one tick
      drain();
      set_timing('0, 1'b0);
      run_phase(200, 1, EV_NONE);

      drain();
      set_timing(random_timing(1, 6), 1'b0);
      run_phase(250, 1, EV_HOLD_OFF);

      drain();
      set_timing(random_timing(0, 4), 1'b1);
      run_phase(250, 1, EV_PAUSE);

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

endmodule
